// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BDD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define BDD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/bdd_pkg.sv -----
// shared types and constants for the bit-packed delta decompressor
`default_nettype none

package bdd_pkg;

  localparam int MAX_CODE_WIDTH_DEF = 24;
  localparam int WORD_BYTES = 4;
  localparam int BYTE_W = 8;
  localparam int WORD_BITS = WORD_BYTES * BYTE_W;
  localparam int ADDR_W = 4;
  localparam logic [31:0] SIGN_BIT = 32'h0080_0000;

  localparam logic [4:0] CODE_WIDTH_RST = 5'd8;
  localparam logic [4:0] SHIFT_RST = 5'd0;
  localparam logic [31:0] GAIN_RST = 32'h1000_0000;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_WIDTH  = 2'd1,
    ST_BAD_SHIFT  = 2'd2,
    ST_ZERO_LIMIT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_CODE_WIDTH = 2'd0,
    REG_SHIFT      = 2'd1,
    REG_GAIN       = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]         code_width;
    logic [4:0]         shift_amount;
    logic signed [31:0] gain;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic word_go;
    logic step_ok;
    logic scan_end;
    logic pend_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/bdd_if.sv -----
// request channel interfaces for input items and result items
`default_nettype none

interface bdd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [23:0] initial_value;
  logic [23:0] sample_limit;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;

  modport source (output valid, op, initial_value, sample_limit, data_word, valid_bytes,
                  input ready);
  modport sink (input valid, op, initial_value, sample_limit, data_word, valid_bytes,
                output ready);
endinterface

interface bdd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] raw_sample;
  logic signed [63:0] scaled_sample;
  logic               last;

  modport source (output valid, status, raw_sample, scaled_sample, last, input ready);
  modport sink (input valid, status, raw_sample, scaled_sample, last, output ready);
endinterface

`default_nettype wire

// ----- sv/bdd_ctrl.sv -----
// controller state machine: item acceptance and bit scan sequencing
`default_nettype none

module bdd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bdd_pkg::dp_stat_t stat,
  output bdd_pkg::dp_cmd_t  cmd
);
  import bdd_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE) && stat.pend_free;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.step   = (state == S_SCAN) && stat.step_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.accept && stat.word_go) state <= S_SCAN;
        end
        S_SCAN: begin
          if (cmd.step && stat.scan_end) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/bdd_dp.sv -----
// datapath: frame state, bit scan, accumulator, result stage and gain multiply
`default_nettype none

module bdd_dp #(
  parameter int MAX_CODE_WIDTH = bdd_pkg::MAX_CODE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bdd_pkg::cfg_t     cfg,
  input  bdd_pkg::dp_cmd_t  cmd,
  output bdd_pkg::dp_stat_t stat,
  input  logic              op,
  input  logic [23:0]       initial_value,
  input  logic [23:0]       sample_limit,
  input  logic [31:0]       data_word,
  input  logic [2:0]        valid_bytes,
  bdd_out_if.source         out_ch
);
  import bdd_pkg::*;

  localparam int BC_W  = $clog2(MAX_CODE_WIDTH + 1);
  localparam int BIT_W = $clog2(WORD_BITS);

  // frame state
  logic [31:0]               acc;
  logic [MAX_CODE_WIDTH-1:0] pm;
  logic [BC_W-1:0]           bc;
  logic                      sgn;
  logic [23:0]               sl;
  logic                      fa;

  // scan state
  logic [WORD_BITS-1:0] scan_sr;
  logic [BIT_W-1:0]     bit_idx;
  logic                 tail;

  // pending result, then output register
  logic        pend_valid;
  status_t     pend_status;
  logic [31:0] pend_raw;
  logic        pend_last;

  logic               out_valid;
  status_t            out_status;
  logic signed [31:0] out_raw;
  logic signed [63:0] out_scaled;
  logic               out_last;

  // checks and start value
  logic        cw_bad, sh_bad, lim_zero;
  logic [31:0] start_sh, start_v;
  logic [23:0] lim_m1;
  status_t     start_status;

  // word assembly
  logic                 nb_zero, tail_in;
  logic [WORD_BITS-1:0] asm_sr;

  // bit step
  logic                      b, is_sign, sgn_step, emit, fin;
  logic [MAX_CODE_WIDTH-1:0] pm_or;
  logic [5:0]                bc_inc;
  logic [31:0]               delta, acc_step;
  logic [23:0]               sl_dec;

  // handshake between pending and output
  logic out_free, pend_move, start_acc, data_acc, pend_load_step;

  // multiply
  logic [31:0]        eff;
  logic signed [63:0] prod;

  assign cw_bad   = (cfg.code_width == 5'd0) ||
                    ({1'b0, cfg.code_width} > 6'(MAX_CODE_WIDTH));
  assign sh_bad   = ({1'b0, cfg.code_width} + {1'b0, cfg.shift_amount}) > 6'(MAX_CODE_WIDTH);
  assign lim_zero = (sample_limit == 24'd0);
  assign lim_m1   = sample_limit - 24'd1;

  always_comb begin
    priority if (cw_bad)   start_status = ST_BAD_WIDTH;
    else if (sh_bad)       start_status = ST_BAD_SHIFT;
    else if (lim_zero)     start_status = ST_ZERO_LIMIT;
    else                   start_status = ST_OK;
  end

  // bit 23 of the shifted value is a sign flag over the magnitude below it
  assign start_sh = {8'd0, initial_value} << cfg.shift_amount;
  assign start_v  = (start_sh & SIGN_BIT) != 32'd0 ? 32'd0 - (start_sh & ~SIGN_BIT) : start_sh;

  // full words scan lane 3 first, tail words lane 0 first; lsb first per lane and in scan_sr
  assign nb_zero = (valid_bytes == 3'd0);
  assign tail_in = (valid_bytes < 3'(WORD_BYTES));
  always_comb begin
    if (tail_in) begin
      asm_sr = {8'd0,
                (valid_bytes > 3'd2) ? data_word[23:16] : 8'd0,
                (valid_bytes > 3'd1) ? data_word[15:8]  : 8'd0,
                data_word[7:0]};
    end else begin
      asm_sr = {data_word[7:0], data_word[15:8], data_word[23:16], data_word[31:24]};
    end
  end

  assign b        = scan_sr[0];
  assign is_sign  = (6'(bc) == ({1'b0, cfg.code_width} - 6'd1));
  assign pm_or    = is_sign ? pm : (pm | ({{(MAX_CODE_WIDTH-1){1'b0}}, b} << bc));
  assign sgn_step = is_sign ? b : sgn;
  assign bc_inc   = 6'(bc) + 6'd1;
  assign emit     = (bc_inc >= {1'b0, cfg.code_width});
  assign delta    = 32'(pm_or) << cfg.shift_amount;
  assign acc_step = sgn_step ? acc - delta : acc + delta;
  assign sl_dec   = sl - 24'd1;
  assign fin      = emit && (sl_dec == 24'd0);

  assign out_free       = !out_valid || out_ch.ready;
  assign pend_move      = pend_valid && out_free;
  assign start_acc      = cmd.accept && !op;
  assign data_acc       = cmd.accept && op;
  assign pend_load_step = cmd.step && emit;

  assign stat.word_go   = op && fa && !nb_zero && !cw_bad;
  assign stat.step_ok   = !pend_valid || pend_move;
  assign stat.scan_end  = (bit_idx == BIT_W'(WORD_BITS - 1)) || fin;
  assign stat.pend_free = !pend_valid;

  assign eff  = (pend_raw == 32'd0) ? 32'd1 : pend_raw;
  assign prod = $signed(eff) * cfg.gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      pm         <= '0;
      bc         <= '0;
      sgn        <= 1'b0;
      sl         <= '0;
      fa         <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (start_acc) begin
        pm          <= '0;
        bc          <= '0;
        sgn         <= 1'b0;
        pend_status <= start_status;
        pend_last   <= (start_status != ST_OK) || (lim_m1 == 24'd0);
        if (start_status == ST_OK) begin
          acc      <= start_v;
          sl       <= lim_m1;
          fa       <= (lim_m1 != 24'd0);
          pend_raw <= start_v;
        end else begin
          sl       <= '0;
          fa       <= 1'b0;
          pend_raw <= '0;
        end
      end else if (data_acc) begin
        if (fa && nb_zero) fa <= 1'b0;
        scan_sr <= asm_sr;
        bit_idx <= '0;
        tail    <= tail_in;
      end else if (cmd.step) begin
        scan_sr <= scan_sr >> 1;
        bit_idx <= bit_idx + BIT_W'(1);
        sgn     <= sgn_step;
        if (emit) begin
          acc         <= acc_step;
          sl          <= sl_dec;
          pm          <= '0;
          bc          <= '0;
          pend_status <= ST_OK;
          pend_raw    <= acc_step;
          pend_last   <= fin;
        end else begin
          pm <= pm_or;
          bc <= BC_W'(bc_inc);
        end
        if (stat.scan_end && (tail || fin)) fa <= 1'b0;
      end

      pend_valid <= start_acc || pend_load_step || (pend_valid && !pend_move);

      if (pend_move) begin
        out_valid  <= 1'b1;
        out_status <= pend_status;
        out_raw    <= $signed(pend_raw);
        out_scaled <= (pend_status == ST_OK) ? prod : 64'sd0;
        out_last   <= pend_last;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = out_status;
  assign out_ch.raw_sample    = out_raw;
  assign out_ch.scaled_sample = out_scaled;
  assign out_ch.last          = out_last;

endmodule

`default_nettype wire

// ----- sv/bitpacked_delta_decompressor.sv -----
// a start result and each sample pass through the pending result register, then the output register
// a data word is accepted in idle and then scanned bit by bit; the scan ends early when the limit
//   ends the frame mid-word; a new item is taken only in idle while the result slot is free
// the bit scan and the single result slot before the output register set the item rate;
//   a stalled output holds the scan until the slot frees
// reset clears all frame state, the result valid flags and the registers to their defaults
`default_nettype none

module bitpacked_delta_decompressor #(
  parameter int MAX_CODE_WIDTH = bdd_pkg::MAX_CODE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  bdd_in_if.sink                     in_ch,
  bdd_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import bdd_pkg::*;

  // configuration registers
  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  // controller / datapath link
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register writes; writes to unmapped addresses are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_width   <= CODE_WIDTH_RST;
      cfg.shift_amount <= SHIFT_RST;
      cfg.gain         <= $signed(GAIN_RST);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CODE_WIDTH: cfg.code_width   <= pwdata[4:0];
        REG_SHIFT:      cfg.shift_amount <= pwdata[4:0];
        REG_GAIN:       cfg.gain         <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      REG_CODE_WIDTH: prdata = {27'd0, cfg.code_width};
      REG_SHIFT:      prdata = {27'd0, cfg.shift_amount};
      REG_GAIN:       prdata = cfg.gain;
      default:        prdata = 32'd0;
    endcase
  end

  // sequencing: idle takes requests, scan walks one word bit by bit
  bdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // frame state, code assembly, accumulator, gain multiply and result registers
  bdd_dp #(
    .MAX_CODE_WIDTH (MAX_CODE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .op            (in_ch.op),
    .initial_value (in_ch.initial_value),
    .sample_limit  (in_ch.sample_limit),
    .data_word     (in_ch.data_word),
    .valid_bytes   (in_ch.valid_bytes),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

// ----- sv/bdd_checker.sv -----
// port-level checker for the decompressor and its bind
`default_nettype none

`include "assert_macros.svh"

module bdd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_op,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_raw,
  input logic signed [63:0] out_scaled,
  input logic               out_last
);
  import bdd_pkg::*;

  logic        err_clean;
  logic [98:0] out_pay;

  assign err_clean = out_last && (out_raw == 32'sd0) && (out_scaled == 64'sd0);
  assign out_pay   = {out_status, out_last, out_raw, out_scaled};

  // an error result carries zero payload and closes the frame
  `BDD_ASSERT_IMPL(a_err_result, clk, rst, out_valid && (out_status != ST_OK), err_clean)

  // a start request always makes a result, so the next request waits
  `BDD_ASSERT_NEXT(a_start_blocks, clk, rst, in_valid && in_ready && !in_op, !in_ready)

  // a result that is not taken stays put
  `BDD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_pay))

endmodule

bind bitpacked_delta_decompressor bdd_checker u_bdd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_op      (in_ch.op),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_raw    (out_ch.raw_sample),
  .out_scaled (out_ch.scaled_sample),
  .out_last   (out_ch.last)
);

`default_nettype wire
